[src/anneal_acceptance_scheduler_defines.svh]
// Assertion macros shared by the annealing scheduler RTL.
// Depends on nothing; include by bare file name.
`ifndef ANNEAL_ACCEPTANCE_SCHEDULER_DEFINES_SVH
`define ANNEAL_ACCEPTANCE_SCHEDULER_DEFINES_SVH
// Assert that antecedent implies consequent on the next clock.
`define AAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
// Assert that a condition holds on every clock outside reset.
`define AAS_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`endif

[src/aas_pkg.sv]
// Package for the annealing scheduler: types, constants, exp fraction table.
// Depends on nothing.
package aas_pkg;
  localparam int unsigned ExpTableBits = 8;
  localparam int unsigned RomSize = 1 << ExpTableBits;
  localparam int unsigned ExpW = 17;
  localparam logic [16:0] Log2eQ16 = 17'd94548;
  localparam logic [13:0] DrawScale = 14'd10000;

  typedef enum logic {OP_START = 1'b0, OP_TRIAL = 1'b1} op_e;
  typedef enum logic [1:0] {
    CFG_INIT_TEMP = 2'd0, CFG_COOL_RATE = 2'd1,
    CFG_STEP_LIMIT = 2'd2, CFG_TRIALS = 2'd3
  } cfg_idx_e;
  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_LOG, ST_CMP, ST_COOL, ST_OUT
  } state_e;

  typedef struct packed {
    logic        op;
    logic [31:0] cost;
    logic [13:0] random_draw;
  } in_item_t;

  typedef struct packed {
    logic        accept;
    logic        cooled;
    logic        finished;
    logic [31:0] current_cost;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] data;
  } cfg_item_t;

  // control between sequencer and divider
  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;

  // 2^(-i/RomSize) in Q1.16 for every i, via Taylor series of exp in Q0.32;
  // evaluated once at elaboration into a constant table
  function automatic logic [RomSize*ExpW-1:0] build_exp_rom();
    logic [RomSize*ExpW-1:0] rom;
    logic [63:0] z, acc, term;
    rom = '0;
    for (int i = 0; i < int'(RomSize); i++) begin
      z = (64'(i) * 64'd2977044472) >> ExpTableBits;
      acc = 64'd1 << 32;
      term = 64'd1 << 32;
      for (int n = 1; n <= 24; n++) begin
        term = ((term * z) >> 32) / 64'(n);
        if (n[0]) acc = acc - term;
        else acc = acc + term;
      end
      acc = (acc + 64'h8000) >> 16;
      rom[i*ExpW +: ExpW] = acc[16:0];
    end
    return rom;
  endfunction

  localparam logic [RomSize*ExpW-1:0] ExpRom = build_exp_rom();
endpackage

[src/aas_if.sv]
// Valid/ready channel interface for the scheduler ports.
// Depends on nothing.
interface aas_if #(parameter int unsigned W = 1) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[src/aas_div.sv]
// Restoring serial divider: 56-bit dividend by 32-bit divisor, 1 bit/cycle.
// Uses aas_pkg.
module aas_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [55:0]     dividend_i,
  input  logic [31:0]     divisor_i,
  output aas_pkg::div_ctl_t ctl_o,
  output logic [55:0]     quot_o
);
  import aas_pkg::*;
  logic [5:0]  cnt_q, cnt_d;
  logic [32:0] rem_q, rem_d;
  logic [55:0] quo_q, quo_d;
  logic [31:0] dvs_q, dvs_d;
  logic [32:0] trial;

  always_comb begin
    cnt_d = cnt_q; rem_d = rem_q; quo_d = quo_q; dvs_d = dvs_q;
    trial = {rem_q[31:0], quo_q[55]} - {1'b0, dvs_q};
    if (start_i) begin
      cnt_d = 6'd56; rem_d = '0; quo_d = dividend_i; dvs_d = divisor_i;
    end else if (cnt_q != 6'd0) begin
      cnt_d = cnt_q - 6'd1;
      if (rem_q[32] || !trial[32]) begin
        rem_d = {1'b0, trial[31:0]};
        if (rem_q[32]) rem_d = {rem_q[31:0], quo_q[55]} - {1'b0, dvs_q};
        quo_d = {quo_q[54:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], quo_q[55]};
        quo_d = {quo_q[54:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; dvs_q <= dvs_d;
  end
  assign ctl_o.start = start_i;
  assign ctl_o.busy  = (cnt_q != 6'd0);
  assign quot_o = quo_q;
endmodule

[src/anneal_acceptance_scheduler.sv]
// Annealing acceptance scheduler: Metropolis test with geometric cooling.
// Path from request accept to response valid: starts, and trials while not
// running, go IDLE, OUT; trials with a drop in cost or zero temperature go IDLE,
// DIV, COOL, OUT; others wait in DIV on the divider, then LOG, CMP, COOL, OUT.
// One request at a time; ready returns the cycle after the response leaves.
// Reset: control and config registers take their defaults, run state clears.
module anneal_acceptance_scheduler (
  input  logic clk_i,
  input  logic rst_ni,
  aas_if.sink   in_if,
  aas_if.source out_if,
  aas_if.sink   cfg_if
);
  import aas_pkg::*;
  `include "anneal_acceptance_scheduler_defines.svh"

  state_e state_q, state_d;
  logic [31:0] init_temp_q;
  logic [15:0] cool_q, limit_q, trials_q;
  logic [31:0] kept_q, temp_q;
  logic [15:0] step_q, trial_q;
  logic        run_q;
  in_item_t    item_q;
  out_item_t   res_q;
  logic        oval_q;
  logic        acc_q, cooled_q;
  logic [47:0] mul_q;   // shared multiplier result
  logic [31:0] mul_a;
  logic [16:0] mul_b;
  logic [48:0] mul_p;
  logic [55:0] quot;
  div_ctl_t    dctl;
  logic        div_go;
  in_item_t    in_item;
  cfg_item_t   cfg;
  logic [31:0] delta;
  logic [16:0] romv, pval;
  logic [31:0] lhs, rhs;

  assign in_item = in_item_t'(in_if.payload);
  assign cfg = cfg_item_t'(cfg_if.payload);
  assign cfg_if.ready = 1'b1;
  assign in_if.ready = (state_q == ST_IDLE) && !oval_q;
  assign out_if.valid = oval_q;
  assign out_if.payload = res_q;
  assign delta = item_q.cost - kept_q;

  aas_div u_div (
    .clk_i, .rst_ni, .start_i(div_go),
    .dividend_i({delta, 24'd0}), .divisor_i(temp_q),
    .ctl_o(dctl), .quot_o(quot)
  );

  // Shared multiplier: log2e scaling, then temperature cooling
  always_comb begin
    mul_a = temp_q; mul_b = {1'b0, cool_q};
    if (state_q == ST_LOG) begin
      mul_a = {11'd0, quot[20:0]}; mul_b = Log2eQ16;
    end
    mul_p = mul_a * mul_b;
  end

  // exp lookup from registered y = x*log2e (Q16.32 in mul_q)
  assign romv = ExpRom[mul_q[31:32-ExpTableBits]*ExpW +: ExpW];
  assign pval = (quot[55:21] != 0 || mul_q[47:32] >= 16'd17) ? 17'd0
                : romv >> mul_q[36:32];
  assign lhs = {15'd0, pval} * DrawScale;
  assign rhs = {2'd0, item_q.random_draw, 16'd0};

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:
        if (in_if.valid && in_if.ready) begin
          if (in_item.op == OP_START) state_d = ST_OUT;
          else if (!run_q) state_d = ST_OUT;
          else state_d = ST_DIV;
        end
      ST_DIV:
        if (item_q.cost < kept_q || temp_q == 32'd0) state_d = ST_COOL;
        else if (!dctl.busy && !div_go) state_d = ST_LOG;
      ST_LOG:  state_d = ST_CMP;
      ST_CMP:  state_d = ST_COOL;
      ST_COOL: state_d = ST_OUT;
      ST_OUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // launch the divide on the first DIV cycle only
  logic div_done_q;
  assign div_go = (state_q == ST_DIV) && !div_done_q &&
                  !(item_q.cost < kept_q || temp_q == 32'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; oval_q <= 1'b0; run_q <= 1'b0;
      init_temp_q <= 32'd6553600; cool_q <= 16'd62259;
      limit_q <= 16'd100; trials_q <= 16'd100;
      kept_q <= '0; temp_q <= '0; step_q <= '0; trial_q <= '0;
      div_done_q <= 1'b0; acc_q <= 1'b0; cooled_q <= 1'b0;
    end else begin
      state_q <= state_d;
      div_done_q <= (state_q == ST_DIV) ? (div_done_q | div_go) : 1'b0;
      if (cfg_if.valid) begin
        case (cfg.index)
          {1'b0, CFG_INIT_TEMP}:  init_temp_q <= cfg.data;
          {1'b0, CFG_COOL_RATE}:  cool_q <= cfg.data[15:0];
          {1'b0, CFG_STEP_LIMIT}: limit_q <= cfg.data[15:0];
          {1'b0, CFG_TRIALS}:     trials_q <= cfg.data[15:0];
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) oval_q <= 1'b0;
      case (state_q)
        ST_IDLE: if (in_if.valid && in_if.ready) begin
          acc_q <= 1'b0; cooled_q <= 1'b0;
          if (in_item.op == OP_START) begin
            kept_q <= in_item.cost; temp_q <= init_temp_q;
            step_q <= 16'd1; trial_q <= '0; run_q <= (16'd1 < limit_q);
          end
        end
        ST_DIV: if (item_q.cost < kept_q) acc_q <= 1'b1;
        ST_CMP: acc_q <= (lhs > rhs);
        ST_COOL: begin
          if (acc_q) kept_q <= item_q.cost;
          if ({1'b0, trial_q} + 17'd1 >= {1'b0, trials_q}) begin
            trial_q <= '0; step_q <= step_q + 16'd1;
            temp_q <= mul_p[47:16]; cooled_q <= 1'b1;
            if (step_q + 16'd1 >= limit_q) run_q <= 1'b0;
          end else trial_q <= trial_q + 16'd1;
        end
        ST_OUT: oval_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) item_q <= in_item;
    if (state_q == ST_LOG) mul_q <= mul_p[47:0];
    if (state_q == ST_OUT) begin
      res_q.accept <= acc_q; res_q.cooled <= cooled_q;
      res_q.finished <= !run_q; res_q.current_cost <= kept_q;
    end
  end

  `AAS_ASSERT_NEXT(a_out_after_seq, clk_i, rst_ni, state_q == ST_OUT, oval_q)
  `AAS_ASSERT_ALWAYS(a_no_accept_busy, clk_i, rst_ni, !(oval_q && in_if.ready))
  `AAS_ASSERT_NEXT(a_div_launch, clk_i, rst_ni, div_go, dctl.busy)
endmodule
